// ----- src/rfcd_pkg.sv -----
// Shared types, constants and helper functions of the fill rectangle decomposer.
`default_nettype none
package rfcd_pkg;

  // Corner rounding radius and the last sequencer step per mode
  localparam int RADIUS    = 6;
  localparam int LAST_TOP  = RADIUS;
  localparam int LAST_ALL  = 2 * RADIUS;
  localparam int STEP_W    = $clog2(LAST_ALL + 2);

  // Screen limits
  localparam int CFG_W     = 13;
  localparam logic [CFG_W-1:0] MAX_SCREEN   = 13'd4096;
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd320;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd240;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  // Command op codes
  localparam logic [1:0] OP_STRICT    = 2'd0;
  localparam logic [1:0] OP_CLIP      = 2'd1;
  localparam logic [1:0] OP_ROUND_TOP = 2'd2;
  localparam logic [1:0] OP_ROUND_ALL = 2'd3;

  // Internal coordinate: 16-bit input plus headroom for offsets
  typedef logic signed [17:0] crd_t;

  // Work classes handed from front to back
  typedef enum logic [1:0] {
    M_SINGLE,
    M_ROUND_TOP,
    M_ROUND_ALL,
    M_REJECT
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] color;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        has_rect;
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic [15:0] color;
    logic        final_item;
  } res_t;

  // Sign extend a 16-bit corner
  function automatic crd_t sx16(input logic [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

  // Span inset, top corners only
  function automatic logic [2:0] inset_top(input logic [2:0] d);
    logic [2:0] r;
    case (d)
      3'd0:    r = 3'd4;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd1;
      3'd4:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Span inset, all corners
  function automatic logic [2:0] inset_all(input logic [2:0] d);
    logic [2:0] r;
    case (d)
      3'd0:    r = 3'd3;
      3'd1:    r = 3'd2;
      3'd2:    r = 3'd1;
      3'd3:    r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/rfcd_front.sv -----
// Front end: checks a fill request against the screen and classifies its work.
`default_nettype none
module rfcd_front (
  input  wire logic [1:0]          op,
  input  wire logic [15:0]         left,
  input  wire logic [15:0]         top,
  input  wire logic [15:0]         right,
  input  wire logic [15:0]         bottom,
  input  wire logic [15:0]         fill_color,
  input  wire rfcd_pkg::crd_t      max_x,
  input  wire rfcd_pkg::crd_t      max_y,
  output rfcd_pkg::cmd_t           cmd
);
  import rfcd_pkg::*;

  crd_t x0, y0, x1, y1;
  logic on_screen;

  assign x0 = sx16(left);
  assign y0 = sx16(top);
  assign x1 = sx16(right);
  assign y1 = sx16(bottom);

  // Whole rectangle upright and on screen
  assign on_screen = (x0 >= 0) && (y0 >= 0) && (x1 >= x0) && (y1 >= y0) &&
                     (x1 <= max_x) && (y1 <= max_y);

  // Pick the work class
  always_comb begin
    cmd.x0    = left;
    cmd.y0    = top;
    cmd.x1    = right;
    cmd.y1    = bottom;
    cmd.color = fill_color;
    if (op == OP_CLIP) begin
      cmd.mode = M_SINGLE;
    end else if (!on_screen) begin
      cmd.mode = M_REJECT;
    end else begin
      case (op)
        OP_STRICT:    cmd.mode = M_SINGLE;
        OP_ROUND_TOP: cmd.mode = M_ROUND_TOP;
        OP_ROUND_ALL: cmd.mode = M_ROUND_ALL;
        default:      cmd.mode = M_SINGLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/rfcd_queue.sv -----
// Two-entry queue of classified requests between front and back ends.
`default_nettype none
module rfcd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire rfcd_pkg::cmd_t  push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output rfcd_pkg::cmd_t       head
);
  import rfcd_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

// ----- src/rfcd_back.sv -----
// Back end: steps through body and corner spans, clips them and emits results.
`default_nettype none
module rfcd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire rfcd_pkg::cmd_t  q_head,
  output logic                 q_pop,
  input  wire rfcd_pkg::crd_t  max_x,
  input  wire rfcd_pkg::crd_t  max_y,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output rfcd_pkg::res_t       res
);
  import rfcd_pkg::*;

  // Registers
  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic              pend_v_r, pend_v_nxt;
  res_t              pend_r, pend_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;

  // Candidate rectangle of the current step
  crd_t              cx0, cy0, cx1, cy1;
  crd_t              bx0, by0, bx1, by1;
  crd_t              dx;
  logic [STEP_W-1:0] sm1, last_step;
  logic [2:0]        d_idx;
  logic              inverted, off_screen, force_err;
  res_t              cand, empty_res, err_res;
  logic              can_push, finish;

  assign bx0 = sx16(cmd_r.x0);
  assign by0 = sx16(cmd_r.y0);
  assign bx1 = sx16(cmd_r.x1);
  assign by1 = sx16(cmd_r.y1);
  assign sm1 = step_r - 1'b1;

  // Step geometry per mode
  always_comb begin
    d_idx     = 3'd0;
    dx        = '0;
    cx0       = bx0;
    cy0       = by0;
    cx1       = bx1;
    cy1       = by1;
    force_err = 1'b0;
    last_step = '0;
    case (cmd_r.mode)
      M_SINGLE: begin
        last_step = '0;
      end
      M_ROUND_TOP: begin
        last_step = STEP_W'(LAST_TOP);
        d_idx     = sm1[2:0];
        if (step_r == '0) begin
          cy0 = by0 + crd_t'(RADIUS);
        end else begin
          dx  = crd_t'({15'd0, inset_top(d_idx)});
          cx0 = bx0 + dx;
          cx1 = bx1 - dx;
          cy0 = by0 + crd_t'({15'd0, d_idx});
          cy1 = cy0;
        end
      end
      M_ROUND_ALL: begin
        last_step = STEP_W'(LAST_ALL);
        d_idx     = sm1[3:1];
        if (step_r == '0) begin
          cy0 = by0 + crd_t'(RADIUS);
          cy1 = by1 - crd_t'(RADIUS);
        end else begin
          dx  = crd_t'({15'd0, inset_all(d_idx)});
          cx0 = bx0 + dx;
          cx1 = bx1 - dx;
          // even steps take the bottom row of the pair
          cy0 = sm1[0] ? (by1 - crd_t'({15'd0, d_idx})) : (by0 + crd_t'({15'd0, d_idx}));
          cy1 = cy0;
        end
      end
      default: begin
        force_err = 1'b1;
      end
    endcase
  end

  // Clip classification
  assign inverted   = force_err || (cx1 < cx0) || (cy1 < cy0);
  assign off_screen = (cx0 > max_x) || (cx1 < 0) || (cy0 > max_y) || (cy1 < 0);

  always_comb begin
    cand            = '0;
    cand.has_rect   = 1'b1;
    cand.left       = (cx0 < 0) ? 12'd0 : cx0[11:0];
    cand.top        = (cy0 < 0) ? 12'd0 : cy0[11:0];
    cand.right      = (cx1 > max_x) ? max_x[11:0] : cx1[11:0];
    cand.bottom     = (cy1 > max_y) ? max_y[11:0] : cy1[11:0];
    cand.color      = cmd_r.color;
    empty_res       = '0;
    empty_res.final_item = 1'b1;
    err_res         = '0;
    err_res.status  = 1'b1;
    err_res.final_item = 1'b1;
  end

  assign can_push = !out_v_r || !res_stall;

  // Sequencer
  always_comb begin
    busy_nxt   = busy_r;
    step_nxt   = step_r;
    cmd_nxt    = cmd_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r && res_stall;
    out_nxt    = out_r;
    finish     = 1'b0;
    q_pop      = 1'b0;

    if (busy_r) begin
      if (step_r > last_step) begin
        // flush: last kept rectangle, or an empty result, ends the request
        if (can_push) begin
          out_v_nxt = 1'b1;
          out_nxt   = pend_v_r ? pend_r : empty_res;
          out_nxt.final_item = 1'b1;
          finish    = 1'b1;
        end
      end else if (inverted) begin
        if (can_push) begin
          out_v_nxt = 1'b1;
          if (pend_v_r) begin
            out_nxt    = pend_r;
            pend_v_nxt = 1'b0;
          end else begin
            out_nxt = err_res;
            finish  = 1'b1;
          end
        end
      end else if (off_screen) begin
        step_nxt = step_r + 1'b1;
      end else if (!pend_v_r) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = cand;
        step_nxt   = step_r + 1'b1;
      end else if (can_push) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
        pend_nxt  = cand;
        step_nxt  = step_r + 1'b1;
      end
    end

    if (finish) begin
      busy_nxt   = 1'b0;
      pend_v_nxt = 1'b0;
    end

    // Take the next request as soon as the sequencer frees up
    if ((!busy_r || finish) && q_not_empty) begin
      q_pop      = 1'b1;
      busy_nxt   = 1'b1;
      step_nxt   = '0;
      cmd_nxt    = q_head;
      pend_v_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      step_r   <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      step_r   <= step_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign res_valid = out_v_r;
  assign res       = out_r;

endmodule
`default_nettype wire

// ----- src/rect_fill_clip_decomposer_unit.sv -----
// Top level of the fill rectangle decomposer: config registers, front, queue, back.
//
//  channel | direction | handshake               | payload
//  in_     | request   | in_valid / in_stall      | op, corners, fill color
//  out_    | result    | out_valid / out_stall    | status, has_rect, corners, color, final
//  cfg_    | write     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// The back end sequencer steps through the sub-rectangles of a request (the body, then
// the corner spans of the rounded modes) and ends it with a closing step, with one
// more step when an error follows an already produced rectangle.
// Requests enter in any cycle with room in the two-entry queue; a result waits in the
// output register while work goes on. Reset (rst_n low, synchronous) empties the
// queue and the sequencer and sets the screen to 320 by 240.
`default_nettype none
module rect_fill_clip_decomposer_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // requests
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_op,
  input  wire logic signed [15:0]                 in_left,
  input  wire logic signed [15:0]                 in_top,
  input  wire logic signed [15:0]                 in_right,
  input  wire logic signed [15:0]                 in_bottom,
  input  wire logic [15:0]                        in_fill_color,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_status,
  output logic                                    out_has_rect,
  output logic [11:0]                             out_left,
  output logic [11:0]                             out_top,
  output logic [11:0]                             out_right,
  output logic [11:0]                             out_bottom,
  output logic [15:0]                             out_color,
  output logic                                    out_final_item,
  // configuration writes
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rfcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rfcd_pkg::CFG_W-1:0]         cfg_data
);
  import rfcd_pkg::*;

  logic [CFG_W-1:0] scr_w_r, scr_h_r;
  logic [CFG_W-1:0] lim_w, lim_h;
  crd_t             max_x, max_y;
  cmd_t             front_cmd, q_head;
  logic             q_full, q_not_empty, q_pop;
  res_t             res;

  // Screen size registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= RESET_WIDTH;
      scr_h_r <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_SCREEN_WIDTH)  scr_w_r <= cfg_data;
      if (cfg_index == CFG_SCREEN_HEIGHT) scr_h_r <= cfg_data;
    end
  end

  // Clamp to the largest panel and form last column / row
  assign lim_w = (scr_w_r > MAX_SCREEN) ? MAX_SCREEN : scr_w_r;
  assign lim_h = (scr_h_r > MAX_SCREEN) ? MAX_SCREEN : scr_h_r;
  assign max_x = crd_t'({5'd0, lim_w}) - crd_t'(1);
  assign max_y = crd_t'({5'd0, lim_h}) - crd_t'(1);

  assign in_stall = q_full;

  rfcd_front u_front (
    .op         (in_op),
    .left       (in_left),
    .top        (in_top),
    .right      (in_right),
    .bottom     (in_bottom),
    .fill_color (in_fill_color),
    .max_x      (max_x),
    .max_y      (max_y),
    .cmd        (front_cmd)
  );

  rfcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && !q_full),
    .push_data (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rfcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .max_x       (max_x),
    .max_y       (max_y),
    .res_valid   (out_valid),
    .res_stall   (out_stall),
    .res         (res)
  );

  assign out_status     = res.status;
  assign out_has_rect   = res.has_rect;
  assign out_left       = res.left;
  assign out_top        = res.top;
  assign out_right      = res.right;
  assign out_bottom     = res.bottom;
  assign out_color      = res.color;
  assign out_final_item = res.final_item;

endmodule
`default_nettype wire

// ----- test/rect_fill_clip_decomposer_unit_tb.sv -----
// Self-checking testbench for the fill rectangle decomposer: fill commands in, clipped rects out.
module rect_fill_clip_decomposer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfcd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  // One fill command as the testbench keeps it
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
    logic [15:0] color;
  } fill_cmd_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_BURST} stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = '0;
  logic signed [15:0] in_left = '0;
  logic signed [15:0] in_top = '0;
  logic signed [15:0] in_right = '0;
  logic signed [15:0] in_bottom = '0;
  logic [15:0]        in_fill_color = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_status;
  logic               out_has_rect;
  logic [11:0]        out_left;
  logic [11:0]        out_top;
  logic [11:0]        out_right;
  logic [11:0]        out_bottom;
  logic [15:0]        out_color;
  logic               out_final_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Screen size as the block should hold it
  logic [CFG_W-1:0] screen_cols;
  logic [CFG_W-1:0] screen_rows;
  int clip_mx;
  int clip_my;

  fill_cmd_t cmd_backlog[$];
  fill_cmd_t active_cmd;
  res_t      cmd_fills[$];
  res_t      expected_fills[$];
  res_t      next_fill;

  logic req_fire = 1'b0;
  bit   steady_flow = 1'b0;
  int   burst_left = 1;
  int   send_gap = 0;
  int   stall_clock = 0;
  int   stall_run = 0;
  stall_mode_t stall_mode = STALL_NONE;

  int mismatches = 0;
  int op_hits[4];
  int rect_results = 0;
  int error_results = 0;
  int empty_results = 0;
  int screens_tried = 1;

  rect_fill_clip_decomposer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_left        (in_left),
    .in_top         (in_top),
    .in_right       (in_right),
    .in_bottom      (in_bottom),
    .in_fill_color  (in_fill_color),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_has_rect   (out_has_rect),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_right      (out_right),
    .out_bottom     (out_bottom),
    .out_color      (out_color),
    .out_final_item (out_final_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Corner span inset per corner row
  function automatic int corner_inset(bit all_corners, int row);
    if (all_corners) begin
      case (row)
        0:       return 3;
        1:       return 2;
        2, 3:    return 1;
        default: return 0;
      endcase
    end else begin
      case (row)
        0:       return 4;
        1:       return 3;
        2:       return 2;
        3, 4:    return 1;
        default: return 0;
      endcase
    end
  endfunction

  // Clip one sub-rect to the screen; returns 0 when it is inverted
  function automatic bit add_span(int x0, int y0, int x1, int y1, logic [15:0] color);
    res_t r;
    if (x1 < x0 || y1 < y0) return 1'b0;
    if (x0 > clip_mx || x1 < 0 || y0 > clip_my || y1 < 0) return 1'b1;
    r = '0;
    r.has_rect = 1'b1;
    r.left = 12'(x0 < 0 ? 0 : x0);
    r.top = 12'(y0 < 0 ? 0 : y0);
    r.right = 12'(x1 > clip_mx ? clip_mx : x1);
    r.bottom = 12'(y1 > clip_my ? clip_my : y1);
    r.color = color;
    cmd_fills.push_back(r);
    return 1'b1;
  endfunction

  // Expected fill rects of one command, appended to expected_fills
  function automatic void predict_fill(fill_cmd_t cmd);
    int w, h, x0, y0, x1, y1, d, dx;
    bit ok;
    res_t r;
    cmd_fills.delete();
    w = (screen_cols > MAX_SCREEN) ? MAX_SCREEN : screen_cols;
    h = (screen_rows > MAX_SCREEN) ? MAX_SCREEN : screen_rows;
    clip_mx = w - 1;
    clip_my = h - 1;
    x0 = $signed(cmd.left);
    y0 = $signed(cmd.top);
    x1 = $signed(cmd.right);
    y1 = $signed(cmd.bottom);
    ok = 1'b1;
    op_hits[cmd.op]++;
    if (cmd.op == OP_CLIP) begin
      ok = add_span(x0, y0, x1, y1, cmd.color);
    end else if (x0 < 0 || y0 < 0 || x1 < x0 || y1 < y0 || x1 >= w || y1 >= h) begin
      ok = 1'b0;
    end else if (cmd.op == OP_STRICT) begin
      ok = add_span(x0, y0, x1, y1, cmd.color);
    end else if (cmd.op == OP_ROUND_TOP) begin
      ok = add_span(x0, y0 + RADIUS, x1, y1, cmd.color);
      for (d = 0; ok && d < RADIUS; d++) begin
        dx = corner_inset(1'b0, d);
        ok = add_span(x0 + dx, y0 + d, x1 - dx, y0 + d, cmd.color);
      end
    end else begin
      // body, then top and bottom span of each corner row in turn
      ok = add_span(x0, y0 + RADIUS, x1, y1 - RADIUS, cmd.color);
      for (d = 0; ok && d < RADIUS; d++) begin
        dx = corner_inset(1'b1, d);
        ok = add_span(x0 + dx, y0 + d, x1 - dx, y0 + d, cmd.color);
        if (ok) ok = add_span(x0 + dx, y1 - d, x1 - dx, y1 - d, cmd.color);
      end
    end
    r = '0;
    if (!ok) begin
      r.status = 1'b1;
      cmd_fills.push_back(r);
    end else if (cmd_fills.size() == 0) begin
      cmd_fills.push_back(r);
    end
    r = cmd_fills.pop_back();
    r.final_item = 1'b1;
    cmd_fills.push_back(r);
    foreach (cmd_fills[i]) begin
      if (cmd_fills[i].status) error_results++;
      else if (cmd_fills[i].has_rect) rect_results++;
      else empty_results++;
      expected_fills.push_back(cmd_fills[i]);
    end
  endfunction

  function automatic fill_cmd_t make_cmd(logic [1:0] op, int l, int t, int r, int b, int c);
    fill_cmd_t cmd;
    cmd.op = op;
    cmd.left = 16'(l);
    cmd.top = 16'(t);
    cmd.right = 16'(r);
    cmd.bottom = 16'(b);
    cmd.color = 16'(c);
    return cmd;
  endfunction

  // Mostly well-formed rects on screen, some straddling or off the edge, some noise
  function automatic fill_cmd_t random_cmd();
    int w, h, sw, sh, x0, y0, kind;
    logic [1:0] op;
    w = (screen_cols > MAX_SCREEN) ? MAX_SCREEN : screen_cols;
    h = (screen_rows > MAX_SCREEN) ? MAX_SCREEN : screen_rows;
    if (w < 1) w = 1;
    if (h < 1) h = 1;
    op = 2'($urandom_range(0, 3));
    kind = $urandom_range(0, 9);
    if (kind == 0)
      return make_cmd(op, $urandom, $urandom, $urandom, $urandom, $urandom);
    sw = ($urandom_range(0, 15) == 0) ? w : $urandom_range(1, (w < 40) ? w : 40);
    sh = ($urandom_range(0, 15) == 0) ? h : $urandom_range(1, (h < 40) ? h : 40);
    x0 = $urandom_range(0, w - sw);
    y0 = $urandom_range(0, h - sh);
    if (kind <= 2) begin
      x0 = x0 + int'($urandom_range(0, 2 * sw + 16)) - (sw + 8);
      y0 = y0 + int'($urandom_range(0, 2 * sh + 16)) - (sh + 8);
    end
    return make_cmd(op, x0, y0, x0 + sw - 1, y0 + sh - 1, $urandom);
  endfunction

  // Request driver: bursts of commands with random gaps
  always @(posedge clk) req_fire <= in_valid && !in_stall;

  always @(negedge clk) begin
    if (req_fire) predict_fill(active_cmd);
    if (!in_valid || req_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        active_cmd = cmd_backlog.pop_front();
        in_op <= active_cmd.op;
        in_left <= active_cmd.left;
        in_top <= active_cmd.top;
        in_right <= active_cmd.right;
        in_bottom <= active_cmd.bottom;
        in_fill_color <= active_cmd.color;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 10);
          if (steady_flow) send_gap = 0;
          else if ($urandom_range(0, 7) == 0) send_gap = $urandom_range(10, 40);
          else send_gap = $urandom_range(0, 4);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall pattern in one of four randomly chosen styles
  always @(negedge clk) begin
    stall_clock++;
    if (stall_clock % 64 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    if (steady_flow || stall_mode == STALL_NONE) begin
      out_stall <= 1'b0;
    end else if (stall_mode == STALL_COIN) begin
      out_stall <= ($urandom_range(0, 1) == 1);
    end else if (stall_mode == STALL_PERIODIC) begin
      out_stall <= (stall_clock % 3 != 0);
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 20);
    end
  end

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fills.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual status %0d rect %0d",
                 $time, out_status, out_has_rect);
      end else begin
        next_fill = expected_fills.pop_front();
        check_field("status", next_fill.status, out_status);
        check_field("has_rect", next_fill.has_rect, out_has_rect);
        check_field("left", next_fill.left, out_left);
        check_field("top", next_fill.top, out_top);
        check_field("right", next_fill.right, out_right);
        check_field("bottom", next_fill.bottom, out_bottom);
        check_field("color", next_fill.color, out_color);
        check_field("final_item", next_fill.final_item, out_final_item);
      end
    end
  end

  task automatic write_screen_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SCREEN_WIDTH) screen_cols = value;
    else if (idx == CFG_SCREEN_HEIGHT) screen_rows = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // All commands accepted and every expected result seen
  task automatic wait_drained();
    do @(posedge clk); while (cmd_backlog.size() != 0 || in_valid);
    do @(negedge clk); while (expected_fills.size() != 0);
  endtask

  initial begin
    int ph;
    screen_cols = RESET_WIDTH;
    screen_rows = RESET_HEIGHT;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed commands on the reset screen of 320 by 240
    cmd_backlog.push_back(make_cmd(OP_STRICT, 0, 0, 319, 239, 'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_STRICT, 10, 20, 10, 20, 0));
    cmd_backlog.push_back(make_cmd(OP_STRICT, 0, 0, 320, 239, 'h1111));
    cmd_backlog.push_back(make_cmd(OP_STRICT, -1, 0, 5, 5, 'h2222));
    cmd_backlog.push_back(make_cmd(OP_STRICT, 5, 5, 4, 5, 'h3333));
    cmd_backlog.push_back(make_cmd(OP_CLIP, -32768, -32768, 32767, 32767, 'h1234));
    cmd_backlog.push_back(make_cmd(OP_CLIP, -1, -1, -1, -1, 'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_CLIP, 320, 0, 400, 10, 'h5555));
    cmd_backlog.push_back(make_cmd(OP_CLIP, 5, 5, 3, 8, 'h6666));
    cmd_backlog.push_back(make_cmd(OP_CLIP, 300, 230, 400, 300, 'h7777));
    cmd_backlog.push_back(make_cmd(OP_ROUND_TOP, 10, 10, 40, 30, 'h8888));
    cmd_backlog.push_back(make_cmd(OP_ROUND_TOP, 0, 0, 319, 239, 'h9999));
    // body inverted right away, then span inverted after the body
    cmd_backlog.push_back(make_cmd(OP_ROUND_TOP, 10, 10, 40, 14, 'hAAAA));
    cmd_backlog.push_back(make_cmd(OP_ROUND_TOP, 10, 10, 16, 30, 'hBBBB));
    cmd_backlog.push_back(make_cmd(OP_ROUND_TOP, -5, 0, 20, 20, 'hCCCC));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 20, 20, 60, 60, 'hDDDD));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 20, 20, 60, 31, 'hEEEE));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 20, 20, 60, 32, 'h0F0F));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 20, 20, 24, 50, 'hF0F0));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 0, 0, 319, 239, 'hA5A5));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 0, 0, 0, 0, 0));
    cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 10, 10, 32767, 100, 'h5A5A));
    wait_drained();

    // Random phases, one screen size each, written while the block is idle
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd1);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd1);
        end
        1: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd4096);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd4096);
        end
        2: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd640);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd480);
        end
        3: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd0);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd240);
        end
        4: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd320);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd0);
        end
        5: begin
          // oversized values act as the maximum screen
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd8191);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd5000);
        end
        6: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'd17);
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'd29);
        end
        default: begin
          write_screen_reg(CFG_SCREEN_WIDTH, 13'($urandom_range(1, 4096)));
          write_screen_reg(CFG_SCREEN_HEIGHT, 13'($urandom_range(1, 4096)));
          write_screen_reg(CFG_UNUSED_INDEX, 13'd0);
        end
      endcase
      screens_tried++;
      steady_flow = (ph == 2);
      cmd_backlog.push_back(make_cmd(OP_CLIP, -32768, -32768, 32767, 32767, $urandom));
      cmd_backlog.push_back(make_cmd(OP_STRICT, 0, 0, screen_cols - 1, screen_rows - 1,
                                     $urandom));
      cmd_backlog.push_back(make_cmd(OP_ROUND_ALL, 0, 0, screen_cols - 1, screen_rows - 1,
                                     $urandom));
      repeat (22) cmd_backlog.push_back(random_cmd());
      wait_drained();
    end
    steady_flow = 1'b0;

    // Let any stray result show up
    repeat (40) @(posedge clk);
    if (expected_fills.size() != 0) begin
      mismatches++;
      $display("%0t ns: missing results, expected %0d more, actual 0",
               $time, expected_fills.size());
    end

    $display("Ran %0d fill commands (strict %0d, clipped %0d, top-rounded %0d, all-rounded %0d)",
             op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
             op_hits[0], op_hits[1], op_hits[2], op_hits[3]);
    $display("on %0d screen sizes: %0d rects, %0d error results, %0d empty results checked",
             screens_tried, rect_results, error_results, empty_results);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/rfcd_pkg.sv
src/rfcd_front.sv
src/rfcd_queue.sv
src/rfcd_back.sv
src/rect_fill_clip_decomposer_unit.sv
test/rect_fill_clip_decomposer_unit_tb.sv
